FILE: rtl/mmpsc_pkg.sv
// Shared types and constants of the multi-mode speed controller.
// Word layouts, register indexes, control-law codes and multiplier ports.
// No dependencies.
package mmpsc_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned SETUP_W     = 5;
  localparam int unsigned PERIOD_W    = 31;
  localparam int unsigned MUL_DIGIT_W = 4;
  localparam int unsigned MUL_DIGITS  = DATA_W / MUL_DIGIT_W;

  localparam logic [CFG_IDX_W-1:0] REG_SETUP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAU    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd7;

  localparam logic [1:0] LAW_P   = 2'd0;
  localparam logic [1:0] LAW_PI  = 2'd1;
  localparam logic [1:0] LAW_PID = 2'd2;
  localparam logic [1:0] LAW_PT1 = 2'd3;

  localparam logic [1:0] WINDUP_RESET = 2'd1;
  localparam logic [1:0] WINDUP_STAB  = 2'd2;

  localparam logic signed [DATA_W-1:0] ZERO_TARGET_LIMIT = 32'sd1311;
  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                     mode;
    logic signed [DATA_W-1:0] sample_value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive_value;
  } out_word_t;

  typedef struct packed {
    logic                     start;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] q;
  } mul_rsp_t;

endpackage

FILE: rtl/mmpsc_stream_if.sv
// Valid/ready channels of the speed controller: sample words in, drive words out.
// Depends on mmpsc_pkg for the word layouts.
interface mmpsc_in_if;
  logic                valid;
  logic                ready;
  mmpsc_pkg::in_word_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface mmpsc_out_if;
  logic                 valid;
  logic                 ready;
  mmpsc_pkg::out_word_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/mmpsc_mul.sv
// Digit-serial Q16.16 multiplier: 4-bit digits of one magnitude per cycle,
// then round to nearest and saturate to 32 bits. Depends on mmpsc_pkg.
module mmpsc_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mmpsc_pkg::mul_req_t req_i,
  output mmpsc_pkg::mul_rsp_t rsp_o
);
  import mmpsc_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MUL_DIGITS);
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned SUM_W  = DATA_W + MUL_DIGIT_W;
  localparam int unsigned RND_W  = PROD_W + 2;
  localparam int unsigned FRAC_W = 16;

  logic [PROD_W-1:0] prod_q;
  logic [DATA_W-1:0] mb_q;
  logic              neg_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              fin_q;
  logic              done_q;
  logic signed [DATA_W-1:0] q_q;

  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;
  logic [SUM_W-1:0]  sum;
  logic [RND_W-1:0]  rnd;
  logic [RND_W-1:0]  rnd_add;
  logic signed [DATA_W-1:0] q_sat;

  assign mag_a = req_i.a[DATA_W-1] ? DATA_W'(-req_i.a) : DATA_W'(req_i.a);
  assign mag_b = req_i.b[DATA_W-1] ? DATA_W'(-req_i.b) : DATA_W'(req_i.b);

  assign sum = SUM_W'(prod_q[PROD_W-1:DATA_W])
             + SUM_W'(SUM_W'(mb_q) * SUM_W'(prod_q[MUL_DIGIT_W-1:0]));

  assign rnd_add = neg_q ? RND_W'((1 << (FRAC_W - 1)) + 1) : RND_W'(1 << (FRAC_W - 1));
  assign rnd     = ({2'b00, prod_q} ^ {RND_W{neg_q}}) + rnd_add;

  always_comb begin
    if ((&rnd[RND_W-1:FRAC_W+DATA_W-1]) || !(|rnd[RND_W-1:FRAC_W+DATA_W-1])) begin
      q_sat = rnd[FRAC_W+DATA_W-1:FRAC_W];
    end else if (rnd[RND_W-1]) begin
      q_sat = S32_MIN;
    end else begin
      q_sat = S32_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MUL_DIGITS - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      prod_q <= {{DATA_W{1'b0}}, mag_a};
      mb_q   <= mag_b;
      neg_q  <= req_i.a[DATA_W-1] ^ req_i.b[DATA_W-1];
    end else if (busy_q) begin
      prod_q <= {sum, prod_q[DATA_W-1:MUL_DIGIT_W]};
    end
    if (fin_q) begin
      q_q <= q_sat;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = q_q;

endmodule

FILE: rtl/multi_mode_pid_speed_controller.sv
// Multi-mode speed controller (P, PI, PID, PT1) on Q16.16 samples.
// Depends on mmpsc_pkg, mmpsc_stream_if and mmpsc_mul.
//
// A set-point word is stored as it is, or in PT1 mode first scaled by the
// correction factor. A measured word needs 2 products for P, 3 for PT1 and 5
// for PI and PID; a word with a zero target needs none. The single shared
// multiplier handles a 32-bit operand four bits per cycle and then rounds.
// The drive word waits in an output register; the next sample is taken
// meanwhile, and a second measured word holds until the first drive is taken.
module multi_mode_pid_speed_controller (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  mmpsc_in_if.sink                             sample_i,
  mmpsc_out_if.source                          drive_o,
  input  logic                                 cfg_we_i,
  input  logic [mmpsc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mmpsc_pkg::DATA_W-1:0]         cfg_wdata_i
);
  import mmpsc_pkg::*;

  localparam int unsigned ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE  = 4'd0;
  localparam logic [ST_W-1:0] S_SPMUL = 4'd1;
  localparam logic [ST_W-1:0] S_INT   = 4'd2;
  localparam logic [ST_W-1:0] S_PROP  = 4'd3;
  localparam logic [ST_W-1:0] S_INTG  = 4'd4;
  localparam logic [ST_W-1:0] S_INTG2 = 4'd5;
  localparam logic [ST_W-1:0] S_DERIV = 4'd6;
  localparam logic [ST_W-1:0] S_PT1   = 4'd7;
  localparam logic [ST_W-1:0] S_CLAMP = 4'd8;
  localparam logic [ST_W-1:0] S_SCALE = 4'd9;
  localparam logic [ST_W-1:0] S_EMIT  = 4'd10;

  localparam int unsigned ACC_W = DATA_W + 2;

  typedef logic signed [DATA_W-1:0] s32_t;
  typedef logic signed [ACC_W-1:0]  s34_t;

  function automatic s32_t sat34(input s34_t x);
    s32_t r;
    if (x > ACC_W'(S32_MAX)) begin
      r = S32_MAX;
    end else if (x < ACC_W'(S32_MIN)) begin
      r = S32_MIN;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic s32_t abs_sat(input s32_t x);
    s32_t r;
    if (x == S32_MIN) begin
      r = S32_MAX;
    end else if (x < 0) begin
      r = -x;
    end else begin
      r = x;
    end
    return r;
  endfunction

  logic [SETUP_W-1:0]  setup_q;
  s32_t                gain_q, tau_q, kd_q, upper_q, lower_q, scale_q;
  logic [PERIOD_W-1:0] period_q;

  logic [ST_W-1:0] state_q, state_d;
  logic            issued_q, issued_d;
  s32_t            target_q, target_d;
  logic            fwd_q, fwd_d;
  s32_t            integ_q, integ_d;
  s32_t            prev_e_q, prev_e_d;
  s32_t            prev_out_q, prev_out_d;
  s32_t            e_q, e_d;
  s32_t            m1_q, m1_d;
  s34_t            acc_q, acc_d;
  s32_t            y_q, y_d;
  s32_t            v_q, v_d;
  logic            out_valid_q, out_valid_d;
  s32_t            out_q, out_d;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  logic     mul_start;

  logic [1:0] law;
  logic [1:0] windup;
  logic       use_dir;
  logic       accept;
  s32_t       v_abs, v_forced, e_new, d_val, inner, t_val, n_up, n_dn;

  assign law     = setup_q[1:0];
  assign windup  = setup_q[3:2];
  assign use_dir = setup_q[4];

  assign sample_i.ready            = (state_q == S_IDLE);
  assign accept                    = sample_i.valid && (state_q == S_IDLE);
  assign drive_o.valid             = out_valid_q;
  assign drive_o.data.drive_value  = out_q;

  assign v_abs    = abs_sat(sample_i.data.sample_value);
  assign v_forced = use_dir ? (fwd_q ? v_abs : -v_abs) : sample_i.data.sample_value;
  assign e_new    = sat34(ACC_W'(target_q) - ACC_W'(v_forced));
  assign d_val    = sat34(ACC_W'(e_q) - ACC_W'(prev_e_q));
  assign inner    = sat34(ACC_W'(m1_q) - ACC_W'(prev_out_q));
  assign t_val    = sat34(ACC_W'(m1_q) + ACC_W'(mul_rsp.q));
  assign n_up     = sat34(ACC_W'(integ_q) + ACC_W'(upper_q) - ACC_W'(t_val));
  assign n_dn     = sat34(ACC_W'(integ_q) + ACC_W'(lower_q) - ACC_W'(t_val));

  always_comb begin
    mul_req.start = mul_start;
    mul_req.a     = gain_q;
    mul_req.b     = e_q;
    unique case (state_q)
      S_SPMUL: begin
        mul_req.a = v_q;
        mul_req.b = kd_q;
      end
      S_INT: begin
        mul_req.a = e_q;
        mul_req.b = DATA_W'(period_q);
      end
      S_INTG, S_INTG2: begin
        mul_req.a = tau_q;
        mul_req.b = integ_q;
      end
      S_DERIV: begin
        mul_req.a = kd_q;
        mul_req.b = d_val;
      end
      S_PT1: begin
        mul_req.a = tau_q;
        mul_req.b = inner;
      end
      S_SCALE: begin
        mul_req.a = y_q;
        mul_req.b = scale_q;
      end
      default: begin
        mul_req.a = gain_q;
        mul_req.b = e_q;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    issued_d    = issued_q;
    target_d    = target_q;
    fwd_d       = fwd_q;
    integ_d     = integ_q;
    prev_e_d    = prev_e_q;
    prev_out_d  = prev_out_q;
    e_d         = e_q;
    m1_d        = m1_q;
    acc_d       = acc_q;
    y_d         = y_q;
    v_d         = v_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !drive_o.ready;
    mul_start   = 1'b0;

    if (state_q != S_IDLE && state_q != S_CLAMP && state_q != S_EMIT && !issued_q) begin
      mul_start = 1'b1;
      issued_d  = 1'b1;
    end
    if (mul_rsp.done) begin
      issued_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (sample_i.data.mode) begin
            if (sample_i.data.sample_value > 0) begin
              fwd_d = 1'b1;
            end else if (sample_i.data.sample_value < 0) begin
              fwd_d = 1'b0;
            end
            if (law == LAW_PT1) begin
              v_d     = sample_i.data.sample_value;
              state_d = S_SPMUL;
            end else begin
              target_d = sample_i.data.sample_value;
            end
          end else if (abs_sat(target_q) < ZERO_TARGET_LIMIT) begin
            integ_d    = '0;
            prev_e_d   = '0;
            prev_out_d = '0;
            y_d        = '0;
            state_d    = S_EMIT;
          end else begin
            e_d = e_new;
            if (law == LAW_PI || law == LAW_PID) begin
              state_d = S_INT;
            end else begin
              state_d = S_PROP;
            end
          end
        end
      end
      S_SPMUL: begin
        if (mul_rsp.done) begin
          target_d = mul_rsp.q;
          state_d  = S_IDLE;
        end
      end
      S_INT: begin
        if (mul_rsp.done) begin
          integ_d = sat34(ACC_W'(integ_q) + ACC_W'(mul_rsp.q));
          state_d = S_PROP;
        end
      end
      S_PROP: begin
        if (mul_rsp.done) begin
          m1_d = mul_rsp.q;
          case (law)
            LAW_P: begin
              y_d     = mul_rsp.q;
              state_d = S_CLAMP;
            end
            LAW_PT1: state_d = S_PT1;
            default: state_d = S_INTG;
          endcase
        end
      end
      S_INTG: begin
        if (mul_rsp.done) begin
          if (law == LAW_PID) begin
            acc_d   = ACC_W'(m1_q) + ACC_W'(mul_rsp.q);
            state_d = S_DERIV;
          end else begin
            if (windup == WINDUP_RESET) begin
              if (t_val >= upper_q || t_val <= lower_q) begin
                integ_d = '0;
              end
            end else if (windup == WINDUP_STAB) begin
              if (t_val >= upper_q) begin
                integ_d = (n_up < 0) ? '0 : n_up;
              end else if (t_val <= lower_q) begin
                integ_d = (n_dn > 0) ? '0 : n_dn;
              end
            end
            state_d = S_INTG2;
          end
        end
      end
      S_INTG2: begin
        if (mul_rsp.done) begin
          y_d     = t_val;
          state_d = S_CLAMP;
        end
      end
      S_DERIV: begin
        if (mul_rsp.done) begin
          y_d      = sat34(acc_q + ACC_W'(mul_rsp.q));
          prev_e_d = e_q;
          state_d  = S_CLAMP;
        end
      end
      S_PT1: begin
        if (mul_rsp.done) begin
          y_d     = sat34(ACC_W'(prev_out_q) + ACC_W'(mul_rsp.q));
          state_d = S_CLAMP;
        end
      end
      S_CLAMP: begin
        if (y_q > upper_q) begin
          y_d = upper_q;
        end else if (y_q < lower_q) begin
          y_d = lower_q;
        end
        state_d = S_SCALE;
      end
      S_SCALE: begin
        if (mul_rsp.done) begin
          y_d        = mul_rsp.q;
          prev_out_d = mul_rsp.q;
          state_d    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || drive_o.ready) begin
          out_valid_d = 1'b1;
          out_d       = y_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  mmpsc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_q  <= 5'd25;
      gain_q   <= 32'sd1048576;
      tau_q    <= 32'sd524288;
      kd_q     <= 32'sd10485760;
      period_q <= 31'd1638;
      upper_q  <= 32'sd1048576;
      lower_q  <= -32'sd1048576;
      scale_q  <= 32'sd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SETUP:  setup_q  <= cfg_wdata_i[SETUP_W-1:0];
        REG_GAIN:   gain_q   <= cfg_wdata_i;
        REG_TAU:    tau_q    <= cfg_wdata_i;
        REG_KD:     kd_q     <= cfg_wdata_i;
        REG_PERIOD: period_q <= cfg_wdata_i[PERIOD_W-1:0];
        REG_UPPER:  upper_q  <= cfg_wdata_i;
        REG_LOWER:  lower_q  <= cfg_wdata_i;
        REG_SCALE:  scale_q  <= cfg_wdata_i;
        default:    setup_q  <= setup_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      target_q    <= '0;
      fwd_q       <= 1'b1;
      integ_q     <= '0;
      prev_e_q    <= '0;
      prev_out_q  <= '0;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
      target_q    <= target_d;
      fwd_q       <= fwd_d;
      integ_q     <= integ_d;
      prev_e_q    <= prev_e_d;
      prev_out_q  <= prev_out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q   <= e_d;
    m1_q  <= m1_d;
    acc_q <= acc_d;
    y_q   <= y_d;
    v_q   <= v_d;
    out_q <= out_d;
  end

endmodule

FILE: rtl/mmpsc_chk.sv
// Port-level checks of the speed controller, bound to the top level.
// Depends on mmpsc_pkg and multi_mode_pid_speed_controller.
module mmpsc_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          in_mode_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [mmpsc_pkg::DATA_W-1:0]  out_data_i
);
  import mmpsc_pkg::*;

  logic [1:0] pending_q, pending_d;
  logic       in_meas;
  logic       out_acc;

  assign in_meas = in_valid_i && in_ready_i && !in_mode_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (in_meas && !out_acc) begin
      pending_d = pending_q + 2'd1;
    end else if (!in_meas && out_acc) begin
      pending_d = pending_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("drive word changed or dropped while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pending_q != 2'd0)
    else $error("drive word without a measured sample");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("too many measured samples in flight");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("drive valid during reset");

endmodule

bind multi_mode_pid_speed_controller mmpsc_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .in_mode_i   (sample_i.data.mode),
  .out_valid_i (drive_o.valid),
  .out_ready_i (drive_o.ready),
  .out_data_i  (drive_o.data.drive_value)
);
